FILE: hw/rtl/key_debounce_autorepeat_defines.svh
// assertion macros shared by the key debounce rtl
// no dependencies; included by the modules that carry checks
`ifndef KEY_DEBOUNCE_AUTOREPEAT_DEFINES_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication, checked outside reset
`define KDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: hw/rtl/kda_pkg.sv
// shared types, codes and constants of the key debounce block
// no dependencies
package kda_pkg;

  localparam int KEY_W        = 8;
  localparam int FUNC_W       = 2;
  localparam int CNT_W        = 16;
  localparam int SETTLE_W     = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int KEY_BITS_DEF     = 8;
  localparam int SETTLE_TICKS_DEF = 4;

  localparam logic [CNT_W-1:0] FIRST_DELAY_RST   = 16'd50;
  localparam logic [CNT_W-1:0] REPEAT_PERIOD_RST = 16'd10;

  typedef enum logic [FUNC_W-1:0] {
    FN_SCAN = 2'd0,
    FN_READ = 2'd1,
    FN_PEEK = 2'd2
  } kda_func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_DELAY   = 2'd0,
    REG_REPEAT_PERIOD = 2'd1
  } kda_reg_t;

  typedef enum logic [1:0] {
    PH_SETTLE = 2'd0,
    PH_FIRST  = 2'd1,
    PH_REPEAT = 2'd2
  } kda_phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] first_delay;
    logic [CNT_W-1:0] repeat_period;
  } kda_cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  raw_key;
  } kda_item_t;

endpackage

FILE: hw/rtl/kda_in_if.sv
// input item channel: function code and raw key
// depends on kda_pkg
interface kda_in_if;
  logic                       valid;
  logic                       ready;
  logic [kda_pkg::FUNC_W-1:0] func;
  logic [kda_pkg::KEY_W-1:0]  raw_key;

  modport source (output valid, output func, output raw_key, input ready);
  modport sink   (input valid, input func, input raw_key, output ready);
endinterface

FILE: hw/rtl/kda_out_if.sv
// result channel: pending key
// depends on kda_pkg
interface kda_out_if;
  logic                      valid;
  logic                      ready;
  logic [kda_pkg::KEY_W-1:0] pending_key;

  modport source (output valid, output pending_key, input ready);
  modport sink   (input valid, input pending_key, output ready);
endinterface

FILE: hw/rtl/kda_cfg_if.sv
// configuration write channel: register index and data
// depends on kda_pkg
interface kda_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kda_pkg::CFG_IDX_W-1:0]  index;
  logic [kda_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/kda_cfg_regs.sv
// delay and period registers written over the configuration channel
// depends on kda_pkg and kda_cfg_if
module kda_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  kda_cfg_if.sink           cfg_ch,
  output kda_pkg::kda_cfg_t cfg
);
  import kda_pkg::*;

  kda_cfg_t cfg_r;
  kda_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FIRST_DELAY:   cfg_nxt.first_delay   = cfg_ch.data;
        REG_REPEAT_PERIOD: cfg_nxt.repeat_period = cfg_ch.data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_delay   <= FIRST_DELAY_RST;
      cfg_r.repeat_period <= REPEAT_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hw/rtl/kda_scan_core.sv
// debounce and auto-repeat state with its combinational next-state update
// depends on kda_pkg and the assertion macro header
`include "key_debounce_autorepeat_defines.svh"

module kda_scan_core #(
  parameter int KEY_BITS     = kda_pkg::KEY_BITS_DEF,
  parameter int SETTLE_TICKS = kda_pkg::SETTLE_TICKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  kda_pkg::kda_item_t        item,
  input  kda_pkg::kda_cfg_t         cfg,
  output logic [kda_pkg::KEY_W-1:0] result_key
);
  import kda_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << KEY_BITS) - 64'd1);
  localparam logic [SETTLE_W-1:0] SETTLE_LAST = SETTLE_W'(SETTLE_TICKS);

  logic [KEY_W-1:0]    current_key_r, current_key_nxt;
  logic [SETTLE_W-1:0] settle_count_r, settle_count_nxt;
  kda_phase_t          phase_r, phase_nxt;
  logic [CNT_W-1:0]    repeat_count_r, repeat_count_nxt;
  logic [KEY_W-1:0]    latched_key_r, latched_key_nxt;
  logic [KEY_W-1:0]    key;

  assign key = item.raw_key & KEY_MASK;

  always_comb begin
    current_key_nxt  = current_key_r;
    settle_count_nxt = settle_count_r;
    phase_nxt        = phase_r;
    repeat_count_nxt = repeat_count_r;
    latched_key_nxt  = latched_key_r;
    result_key       = latched_key_r;
    if (en) begin
      case (item.func)
        FN_SCAN: begin
          if (key != current_key_r) begin
            current_key_nxt  = key;
            settle_count_nxt = '0;
            phase_nxt        = PH_SETTLE;
          end else begin
            case (phase_r)
              PH_REPEAT: begin
                if (repeat_count_r == cfg.repeat_period) begin
                  latched_key_nxt  = current_key_r;
                  repeat_count_nxt = '0;
                end else begin
                  repeat_count_nxt = repeat_count_r + CNT_W'(1);
                end
              end
              PH_FIRST: begin
                if (repeat_count_r == cfg.first_delay) begin
                  latched_key_nxt  = current_key_r;
                  phase_nxt        = PH_REPEAT;
                  repeat_count_nxt = '0;
                end else begin
                  repeat_count_nxt = repeat_count_r + CNT_W'(1);
                end
              end
              default: begin
                if (settle_count_r == SETTLE_LAST) begin
                  if (current_key_r != '0) begin
                    latched_key_nxt  = current_key_r;
                    phase_nxt        = PH_FIRST;
                    repeat_count_nxt = '0;
                  end
                end else begin
                  settle_count_nxt = settle_count_r + SETTLE_W'(1);
                end
              end
            endcase
          end
          result_key = latched_key_nxt;
        end
        FN_READ: begin
          latched_key_nxt = '0;
        end
        default: begin
          latched_key_nxt = latched_key_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_key_r  <= '0;
      settle_count_r <= '0;
      phase_r        <= PH_SETTLE;
      repeat_count_r <= '0;
      latched_key_r  <= '0;
    end else begin
      current_key_r  <= current_key_nxt;
      settle_count_r <= settle_count_nxt;
      phase_r        <= phase_nxt;
      repeat_count_r <= repeat_count_nxt;
      latched_key_r  <= latched_key_nxt;
    end
  end

  `KDA_ASSERT_NOW(a_held_key_nonzero, clk, rst_n, phase_r != PH_SETTLE, current_key_r != '0)
  `KDA_ASSERT_NOW(a_settled_before_repeat, clk, rst_n, phase_r != PH_SETTLE,
                  settle_count_r == SETTLE_LAST)
  `KDA_ASSERT_NEXT(a_read_clears, clk, rst_n, en && item.func == FN_READ, latched_key_r == '0)

endmodule

FILE: hw/rtl/key_debounce_autorepeat.sv
// top level of the keyboard debounce with auto-repeat
// depends on kda_pkg, the channel interfaces, kda_cfg_regs, kda_scan_core and the macro header
`include "key_debounce_autorepeat_defines.svh"

// Every item on the input channel gives exactly one result. A scan tick
// (func 0) carries the raw key code of that tick and returns the pending key
// after the tick's update; a read (func 1) returns the pending key and clears
// it; a peek (func 2, and the unused code 3) returns it unchanged. A key is
// latched once it has held its code for SETTLE_TICKS+1 further ticks, again
// after first_delay+1 more ticks and then every repeat_period+1 ticks while
// held. The block takes one item every clock cycle unless the result channel
// holds it back: an item is held in the input register, then updates the
// state and loads the result register as it moves on; the combinational
// compare-and-count update sets the rate. Configuration writes are always
// ready and take effect in the cycle after the transfer; they must be made
// only while no item is in flight, a rule that the block itself does not
// enforce.
module key_debounce_autorepeat #(
  parameter int KEY_BITS     = kda_pkg::KEY_BITS_DEF,
  parameter int SETTLE_TICKS = kda_pkg::SETTLE_TICKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  kda_in_if.sink     in_ch,
  kda_out_if.source  out_ch,
  kda_cfg_if.sink    cfg_ch
);
  import kda_pkg::*;

  kda_cfg_t         cfg;
  kda_item_t        item_r;
  logic             in_valid_r;
  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic [KEY_W-1:0] result_key;
  logic             advance;
  logic             in_take;

  // the held item moves on when the result register is free or being emptied
  assign advance  = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take  = in_ch.valid && in_ch.ready;

  // input register is refilled when empty or when its item moves on
  assign in_ch.ready        = !in_valid_r || advance;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.pending_key = out_key_r;

  kda_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  kda_scan_core #(
    .KEY_BITS     (KEY_BITS),
    .SETTLE_TICKS (SETTLE_TICKS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .item       (item_r),
    .cfg        (cfg),
    .result_key (result_key)
  );

  // valid flags of both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.func    <= in_ch.func;
      item_r.raw_key <= in_ch.raw_key;
    end
    if (advance) begin
      out_key_r <= result_key;
    end
  end

  `KDA_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_ch.ready,
                  in_valid_r && out_valid_r && !out_ch.ready)
  `KDA_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_r)
  `KDA_ASSERT_NEXT(a_empty_out_follows_in, clk, rst_n, !out_valid_r,
                   out_valid_r == $past(in_valid_r))

endmodule
